/* design/ftfb_pkg.sv */
// ----------------------------------------------------------------------------
// ftfb_pkg: shared types and constants for the file table
// Request and status codes, field widths and default sizes.
// ----------------------------------------------------------------------------
package ftfb_pkg;

  localparam int ENTRY_COUNT_DEF    = 16;
  localparam int BLOCK_CAPACITY_DEF = 256;

  localparam int REQ_W  = 2;
  localparam int ID_W   = 16;
  localparam int CFG_W  = 9;
  localparam int STAT_W = 3;
  localparam int EOUT_W = 4;
  localparam int BOUT_W = 8;
  localparam int CNT_W  = 9;

  // blocks 0 and 1 are never handed out
  localparam int RSV_BLOCKS = 2;
  localparam logic [CFG_W-1:0] CFG_RESET = 9'd256;

  typedef enum logic [REQ_W-1:0] {
    REQ_LOOKUP = 2'd0,
    REQ_CREATE = 2'd1,
    REQ_DELETE = 2'd2,
    REQ_NONE   = 2'd3
  } req_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_EXISTS    = 3'd2,
    ST_NO_BLOCK  = 3'd3,
    ST_NO_ENTRY  = 3'd4
  } status_t;

endpackage

/* design/ftfb_ram.sv */
// ----------------------------------------------------------------------------
// ftfb_ram: simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ftfb_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

/* design/file_table_with_free_block_map.sv */
// ----------------------------------------------------------------------------
// file_table_with_free_block_map: file entry table with a free block map
// Request channel: start/busy with req_type and file_id; a transfer happens
//   at a clock edge with start high and busy low.
// Result channel: done is high for one cycle with status, entry_index,
//   block_index and used_blocks; there is no backpressure.
// Config: cfg_we/cfg_wdata write blocks_in_use (write only while idle).
// Timing: counter eidx walks the entry RAM, then for a create counter bidx
//   walks the block map RAM, one address per cycle with registered read data.
//   Lookup/delete/failed create: done rises at the end of the entry scan
//   (earlier on a hit). Create that scans blocks: the block scan runs up to
//   limit - 1 at most, limit = min(blocks_in_use, BLOCK_CAPACITY). busy
//   drops together with done, so the next request can transfer in the done
//   cycle.
// Reset: entry valid bits clear and the used count loads RSV_BLOCKS at once;
//   then a pass over all addresses writes the block map (busy high meanwhile).
// ----------------------------------------------------------------------------
module file_table_with_free_block_map
  import ftfb_pkg::*;
#(
  parameter int ENTRY_COUNT    = ENTRY_COUNT_DEF,
  parameter int BLOCK_CAPACITY = BLOCK_CAPACITY_DEF
) (
  input  logic              clk,
  input  logic              rst,
  // request transfer
  input  logic              start,
  output logic              busy,
  input  logic [REQ_W-1:0]  req_type,
  input  logic [ID_W-1:0]   file_id,
  // config write
  input  logic              cfg_we,
  input  logic [CFG_W-1:0]  cfg_wdata,
  // result transfer
  output logic              done,
  output logic [STAT_W-1:0] status,
  output logic [EOUT_W-1:0] entry_index,
  output logic [BOUT_W-1:0] block_index,
  output logic [CNT_W-1:0]  used_blocks
);

  localparam int EW   = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
  localparam int BW   = $clog2(BLOCK_CAPACITY);
  localparam int CMPW = (BW + 1 > CFG_W) ? BW + 1 : CFG_W;
  localparam int EDW  = ID_W + BW;

  localparam logic [EW-1:0]    E_LAST   = EW'(ENTRY_COUNT - 1);
  localparam logic [BW-1:0]    B_LAST   = BW'(BLOCK_CAPACITY - 1);
  localparam logic [BW-1:0]    B_FIRST  = BW'(RSV_BLOCKS);
  localparam logic [CMPW-1:0]  CAP_X    = CMPW'(BLOCK_CAPACITY);
  localparam logic [CMPW-1:0]  RSV_X    = CMPW'(RSV_BLOCKS);
  localparam logic [CNT_W-1:0] CNT_MAX  = '1;
  localparam logic [CNT_W-1:0] CNT_INIT = CNT_W'(RSV_BLOCKS);

  typedef enum logic [1:0] {
    S_CLEAR,  // block map init pass after reset
    S_IDLE,
    S_ESCAN,  // id match + first free entry
    S_BSCAN   // lowest free block from 2 up to limit - 1
  } state_t;

  state_t                 state;
  req_t                   req;
  logic [ID_W-1:0]        req_id;
  logic [CFG_W-1:0]       blocks_in_use;
  logic [ENTRY_COUNT-1:0] entry_valid;
  logic [CNT_W-1:0]       used_count;

  // scan pointers: *idx is the address issued, *cmp the one being checked
  logic [EW-1:0] eidx, ecmp, free_idx;
  logic          ecmp_vld, free_found;
  logic [BW-1:0] bidx, bcmp, blast;
  logic          bcmp_vld;

  // RAM ports
  logic [EDW-1:0] erd_data;
  logic [ID_W-1:0] erd_id;
  logic [BW-1:0]  erd_blk;
  logic           brd_used;
  logic           bwr_en, bwr_data;
  logic [BW-1:0]  bwr_addr;

  // scan decisions
  logic            e_hit, e_last, b_free, b_last;
  logic [CMPW-1:0] cfg_x, lim;
  logic [CNT_W-1:0] cnt_inc, cnt_dec;
  logic            fin, go_bscan, del_commit, new_commit;
  status_t         fin_status;
  logic [EW-1:0]   fin_ent;
  logic [BW-1:0]   fin_blk;
  logic [CNT_W-1:0] fin_cnt;

  assign busy = (state != S_IDLE);

  assign erd_id  = erd_data[EDW-1:BW];
  assign erd_blk = erd_data[BW-1:0];

  always_comb begin
    cfg_x = CMPW'(blocks_in_use);
    lim   = (cfg_x > CAP_X) ? CAP_X : cfg_x;
  end

  assign cnt_inc = (used_count == CNT_MAX) ? used_count : used_count + 1'b1;
  assign cnt_dec = (used_count == '0) ? used_count : used_count - 1'b1;

  assign e_hit  = ecmp_vld && entry_valid[ecmp] && (erd_id == req_id);
  assign e_last = ecmp_vld && (ecmp == E_LAST);
  assign b_free = bcmp_vld && !brd_used;
  assign b_last = bcmp_vld && (bcmp == blast);

  always_comb begin
    fin        = 1'b0;
    go_bscan   = 1'b0;
    del_commit = 1'b0;
    new_commit = 1'b0;
    fin_status = ST_NOT_FOUND;
    fin_ent    = '0;
    fin_blk    = '0;
    fin_cnt    = used_count;
    if (state == S_ESCAN && (e_hit || e_last)) begin
      unique case (req)
        REQ_LOOKUP: begin
          fin = 1'b1;
          if (e_hit) begin
            fin_status = ST_OK;
            fin_ent    = ecmp;
            fin_blk    = erd_blk;
          end
        end
        REQ_DELETE: begin
          fin = 1'b1;
          if (e_hit) begin
            del_commit = 1'b1;
            fin_status = ST_OK;
            fin_ent    = ecmp;
            fin_blk    = erd_blk;
            fin_cnt    = cnt_dec;
          end
        end
        REQ_CREATE: begin
          if (e_hit) begin
            fin        = 1'b1;
            fin_status = ST_EXISTS;
          end else if (lim <= RSV_X) begin
            fin        = 1'b1;
            fin_status = ST_NO_BLOCK;
          end else begin
            go_bscan = 1'b1;
          end
        end
        default: begin
          fin = 1'b1;
        end
      endcase
    end else if (state == S_BSCAN && (b_free || b_last)) begin
      fin = 1'b1;
      if (!b_free) begin
        fin_status = ST_NO_BLOCK;
      end else if (!free_found) begin
        fin_status = ST_NO_ENTRY;
      end else begin
        new_commit = 1'b1;
        fin_status = ST_OK;
        fin_ent    = free_idx;
        fin_blk    = bcmp;
        fin_cnt    = cnt_inc;
      end
    end
  end

  // block map write: init pass, free on delete, claim on create
  always_comb begin
    bwr_en   = (state == S_CLEAR) || del_commit || new_commit;
    bwr_addr = bcmp;
    bwr_data = new_commit;
    if (state == S_CLEAR) begin
      bwr_addr = bidx;
      bwr_data = (bidx < B_FIRST);
    end else if (del_commit) begin
      bwr_addr = erd_blk;
    end
  end

  ftfb_ram #(
    .DEPTH (ENTRY_COUNT),
    .WIDTH (EDW)
  ) u_entry_ram (
    .clk     (clk),
    .wr_en   (new_commit),
    .wr_addr (free_idx),
    .wr_data ({req_id, bcmp}),
    .rd_addr (eidx),
    .rd_data (erd_data)
  );

  ftfb_ram #(
    .DEPTH (BLOCK_CAPACITY),
    .WIDTH (1)
  ) u_block_ram (
    .clk     (clk),
    .wr_en   (bwr_en),
    .wr_addr (bwr_addr),
    .wr_data (bwr_data),
    .rd_addr (bidx),
    .rd_data (brd_used)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      bidx          <= '0;
      done          <= 1'b0;
      entry_valid   <= '0;
      used_count    <= CNT_INIT;
      blocks_in_use <= CFG_RESET;
      ecmp_vld      <= 1'b0;
      bcmp_vld      <= 1'b0;
      free_found    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_we) begin
        blocks_in_use <= cfg_wdata;
      end
      unique case (state)
        S_CLEAR: begin
          if (bidx == B_LAST) begin
            state <= S_IDLE;
          end else begin
            bidx <= bidx + 1'b1;
          end
        end
        S_IDLE: begin
          if (start) begin
            req        <= req_t'(req_type);
            req_id     <= file_id;
            eidx       <= '0;
            ecmp_vld   <= 1'b0;
            free_found <= 1'b0;
            state      <= S_ESCAN;
          end
        end
        S_ESCAN: begin
          ecmp     <= eidx;
          ecmp_vld <= 1'b1;
          if (eidx != E_LAST) begin
            eidx <= eidx + 1'b1;
          end
          if (ecmp_vld && !entry_valid[ecmp] && !free_found) begin
            free_found <= 1'b1;
            free_idx   <= ecmp;
          end
          if (del_commit) begin
            entry_valid[ecmp] <= 1'b0;
          end
          if (go_bscan) begin
            bidx     <= B_FIRST;
            bcmp_vld <= 1'b0;
            blast    <= BW'(lim - 1'b1);
            state    <= S_BSCAN;
          end
        end
        S_BSCAN: begin
          bcmp     <= bidx;
          bcmp_vld <= 1'b1;
          if (bidx != blast) begin
            bidx <= bidx + 1'b1;
          end
          if (new_commit) begin
            entry_valid[free_idx] <= 1'b1;
          end
        end
      endcase
      if (fin) begin
        done        <= 1'b1;
        status      <= fin_status;
        entry_index <= EOUT_W'(fin_ent);
        block_index <= BOUT_W'(fin_blk);
        used_blocks <= fin_cnt;
        used_count  <= fin_cnt;
        state       <= S_IDLE;
      end
    end
  end

`ifndef ASSERT_OFF
  // a result only follows work in progress
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result without a request in progress");

  // an accepted request holds the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");

  // one result per request
  a_single_done: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("two results back to back");

  // failures carry zero indexes
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status != ST_OK) |-> (entry_index == '0 && block_index == '0))
    else $error("failed request reported nonzero index");

  // reserved blocks are always counted
  a_count_floor: assert property (@(posedge clk) disable iff (rst)
    used_count >= CNT_INIT)
    else $error("used block count below reserved blocks");
`endif

endmodule

/* dv/tb_file_table_with_free_block_map.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_file_table_with_free_block_map: self-checking bench for the file table
// Drives lookup/create/delete requests through the start/busy port, mirrors
// the entry table and block map in a tracker class, and checks every result
// transfer field by field. Runs a directed opening, then random phases at
// several map sizes (in range, out of range, too small to allocate).
// ----------------------------------------------------------------------------
module tb_file_table_with_free_block_map;
  import ftfb_pkg::*;

  localparam int STALL_LIMIT = 2000;  // above the slowest create plus request gap, and the reset pass
  localparam int SETTLE_CYCLES = 300;
  localparam int ID_POOL = 24;

  typedef struct packed {
    status_t           status;
    logic [EOUT_W-1:0] entry;
    logic [BOUT_W-1:0] block;
    logic [CNT_W-1:0]  used;
  } table_reply_t;

  // Mirror of the file table: entries, block map, used count, map size.
  // note_request() predicts the reply for each accepted request transfer,
  // check_reply() compares each result transfer with the oldest prediction.
  class table_tracker;
    logic             slot_valid [ENTRY_COUNT_DEF];
    logic [ID_W-1:0]  slot_id    [ENTRY_COUNT_DEF];
    logic [BOUT_W-1:0] slot_block [ENTRY_COUNT_DEF];
    logic             blk_free   [BLOCK_CAPACITY_DEF];
    logic [CNT_W-1:0] used_cnt;
    logic [CFG_W-1:0] map_size;
    table_reply_t     expected_replies [$];
    int               errors;
    int               checked;
    int               outcome_cnt [5];

    function new();
      map_size = CFG_RESET;
      used_cnt = CNT_W'(RSV_BLOCKS);
      foreach (slot_valid[i]) begin
        slot_valid[i] = 1'b0;
        slot_id[i]    = '0;
        slot_block[i] = '0;
      end
      foreach (blk_free[b]) blk_free[b] = (b >= RSV_BLOCKS);
      errors  = 0;
      checked = 0;
      foreach (outcome_cnt[k]) outcome_cnt[k] = 0;
    endfunction

    function void set_map_size(logic [CFG_W-1:0] v);
      map_size = v;
    endfunction

    // lowest valid entry holding this id, -1 if none
    function int find_file(logic [ID_W-1:0] id);
      for (int i = 0; i < ENTRY_COUNT_DEF; i++)
        if (slot_valid[i] && slot_id[i] == id) return i;
      return -1;
    endfunction

    // lowest free block from 2 up to min(map size, capacity) - 1
    function int lowest_free_block();
      int lim;
      lim = (map_size > BLOCK_CAPACITY_DEF) ? BLOCK_CAPACITY_DEF : int'(map_size);
      for (int b = RSV_BLOCKS; b < lim; b++)
        if (blk_free[b]) return b;
      return -1;
    endfunction

    function void note_request(req_t kind, logic [ID_W-1:0] id);
      table_reply_t r;
      int hit;
      int slot;
      int blk;
      r.status = ST_NOT_FOUND;
      r.entry  = '0;
      r.block  = '0;
      hit = find_file(id);
      case (kind)
        REQ_LOOKUP: begin
          if (hit >= 0) begin
            r.status = ST_OK;
            r.entry  = EOUT_W'(hit);
            r.block  = slot_block[hit];
          end
        end
        REQ_CREATE: begin
          blk  = lowest_free_block();
          slot = -1;
          for (int i = ENTRY_COUNT_DEF - 1; i >= 0; i--)
            if (!slot_valid[i]) slot = i;
          // duplicate beats everything; missing block beats missing entry
          if (hit >= 0) r.status = ST_EXISTS;
          else if (blk < 0) r.status = ST_NO_BLOCK;
          else if (slot < 0) r.status = ST_NO_ENTRY;
          else begin
            blk_free[blk]    = 1'b0;
            slot_valid[slot] = 1'b1;
            slot_id[slot]    = id;
            slot_block[slot] = BOUT_W'(blk);
            if (used_cnt < 9'd511) used_cnt++;
            r.status = ST_OK;
            r.entry  = EOUT_W'(slot);
            r.block  = BOUT_W'(blk);
          end
        end
        REQ_DELETE: begin
          if (hit >= 0) begin
            r.status = ST_OK;
            r.entry  = EOUT_W'(hit);
            r.block  = slot_block[hit];
            blk_free[slot_block[hit]] = 1'b1;
            slot_valid[hit] = 1'b0;
            slot_id[hit]    = '0;
            slot_block[hit] = '0;
            if (used_cnt > 0) used_cnt--;
          end
        end
        default: ;  // unused code: not found, nothing changes
      endcase
      r.used = used_cnt;
      expected_replies.push_back(r);
    endfunction

    function void check_reply(logic [STAT_W-1:0] st, logic [EOUT_W-1:0] ent,
                              logic [BOUT_W-1:0] blk, logic [CNT_W-1:0] used);
      table_reply_t want;
      if (expected_replies.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("ERROR %0t: unexpected result status=%0d entry=%0d block=%0d used=%0d",
                   $realtime, st, ent, blk, used);
        return;
      end
      want = expected_replies.pop_front();
      checked++;
      outcome_cnt[int'(want.status)]++;
      if (st !== want.status || ent !== want.entry || blk !== want.block ||
          used !== want.used) begin
        errors++;
        if (errors <= 10)
          $display("ERROR %0t: result #%0d exp st=%0d e=%0d b=%0d u=%0d got st=%0d e=%0d b=%0d u=%0d",
                   $realtime, checked, want.status, want.entry, want.block, want.used,
                   st, ent, blk, used);
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst;
  logic              start;
  logic              busy;
  logic [REQ_W-1:0]  req_type;
  logic [ID_W-1:0]   file_id;
  logic              cfg_we;
  logic [CFG_W-1:0]  cfg_wdata;
  logic              done;
  logic [STAT_W-1:0] status;
  logic [EOUT_W-1:0] entry_index;
  logic [BOUT_W-1:0] block_index;
  logic [CNT_W-1:0]  used_blocks;

  table_tracker sb = new();

  int  n_sent = 0;
  int  n_sizes = 0;
  int  stall_cycles = 0;
  bit  back_to_back = 1'b0;
  logic [ID_W-1:0] id_pool [ID_POOL];

  file_table_with_free_block_map dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .req_type   (req_type),
    .file_id    (file_id),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .done       (done),
    .status     (status),
    .entry_index(entry_index),
    .block_index(block_index),
    .used_blocks(used_blocks)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Result side: no backpressure, so every done cycle is a transfer.
  always @(posedge clk) begin
    if (!rst && done === 1'b1)
      sb.check_reply(status, entry_index, block_index, used_blocks);
  end

  // Watchdog: count cycles with neither a request nor a result transfer.
  initial begin
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((start === 1'b1 && busy === 1'b0) || done === 1'b1) stall_cycles = 0;
      else stall_cycles++;
    end
    $display("ERROR: no transfer for %0d cycles, %0d results outstanding",
             STALL_LIMIT, sb.expected_replies.size());
    $display("*** FAILED ***");
    $finish;
  end

  // Present one request and hold it until the transfer. Entered and left at a
  // falling edge; start stays high on exit so a back-to-back request never
  // drops it within one time step.
  task automatic send_request(input req_t kind, input logic [ID_W-1:0] id);
    int gap;
    if (n_sent % 16 == 0) back_to_back = ($urandom_range(0, 3) == 0);
    gap = back_to_back ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start    <= 1'b1;
    req_type <= kind;
    file_id  <= id;
    do @(posedge clk); while (busy !== 1'b0);
    sb.note_request(kind, id);
    n_sent++;
    @(negedge clk);
  endtask

  // Drop start and wait until every predicted result has come back.
  task automatic settle();
    start <= 1'b0;
    while (sb.expected_replies.size() != 0) @(negedge clk);
  endtask

  // Map size is only changed with the block idle.
  task automatic write_map_size(input logic [CFG_W-1:0] v);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_map_size(v);
    n_sizes++;
  endtask

  initial begin
    int sizes [8];
    int lengths [8];
    int pick;
    req_t kind;
    logic [ID_W-1:0] id;

    rst       = 1'b1;
    start     = 1'b0;
    req_type  = REQ_LOOKUP;
    file_id   = '0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    foreach (id_pool[i]) id_pool[i] = ID_W'($urandom);

    repeat (6) @(negedge clk);
    rst <= 1'b0;
    // busy stays high through the block map clearing pass
    do @(posedge clk); while (busy !== 1'b0);
    @(negedge clk);
    write_map_size(CFG_RESET);

    // --- directed opening ---
    send_request(REQ_LOOKUP, 16'h0000);   // empty table miss
    send_request(REQ_DELETE, 16'hFFFF);   // delete of unknown id
    send_request(REQ_CREATE, 16'h0000);   // first block handed out is 2
    send_request(REQ_CREATE, 16'hFFFF);
    send_request(REQ_CREATE, 16'h0000);   // duplicate id
    send_request(REQ_LOOKUP, 16'hFFFF);
    send_request(REQ_NONE,   16'h0000);   // unused code is ignored
    send_request(REQ_DELETE, 16'h0000);   // frees entry 0 and block 2
    send_request(REQ_CREATE, 16'h1234);   // lowest entry and block reused
    send_request(REQ_LOOKUP, 16'h0000);
    for (int k = 0; k < 14; k++) send_request(REQ_CREATE, 16'h0100 + 16'(k));
    send_request(REQ_LOOKUP, 16'h0105);
    send_request(REQ_CREATE, 16'h5555);   // table full
    // map shrunk to one usable block, already taken
    write_map_size(9'd3);
    send_request(REQ_CREATE, 16'hAAAA);   // no block and no entry: block wins
    send_request(REQ_DELETE, 16'hFFFF);   // frees block 3, outside the map
    send_request(REQ_CREATE, 16'hAAAA);   // entry free, still no block
    send_request(REQ_DELETE, 16'h1234);   // frees block 2
    send_request(REQ_CREATE, 16'hAAAA);

    // --- random phases over several map sizes ---
    sizes   = '{256, 511, 40, 3, 0, 2, 0, 256};
    lengths = '{90, 90, 90, 80, 40, 40, 90, 90};
    sizes[6] = $urandom_range(3, 256);
    foreach (sizes[p]) begin
      write_map_size(CFG_W'(sizes[p]));
      for (int n = 0; n < lengths[p]; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 30) kind = REQ_LOOKUP;
        else if (pick < 70) kind = REQ_CREATE;
        else if (pick < 95) kind = REQ_DELETE;
        else kind = REQ_NONE;
        // mostly a small id pool so hits, duplicates and a full table occur
        id = ($urandom_range(0, 9) == 0) ? ID_W'($urandom)
                                         : id_pool[$urandom_range(0, ID_POOL - 1)];
        send_request(kind, id);
      end
    end

    settle();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (sb.expected_replies.size() != 0) begin
      $display("ERROR: %0d results never arrived", sb.expected_replies.size());
      sb.errors += sb.expected_replies.size();
    end

    $display("Sent %0d requests over %0d map size settings, %0d results checked.",
             n_sent, n_sizes, sb.checked);
    $display("Outcomes: %0d ok, %0d not found, %0d duplicate, %0d no block, %0d no entry.",
             sb.outcome_cnt[ST_OK], sb.outcome_cnt[ST_NOT_FOUND], sb.outcome_cnt[ST_EXISTS],
             sb.outcome_cnt[ST_NO_BLOCK], sb.outcome_cnt[ST_NO_ENTRY]);
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* files.f */
design/ftfb_pkg.sv
design/ftfb_ram.sv
design/file_table_with_free_block_map.sv
dv/tb_file_table_with_free_block_map.sv
